// File: hw/rtl/rvex_pkg.sv
// Shared types, opcodes and helpers for the RV32I execute core.
// No dependencies; every other file but rvex_stream_if imports this package.
package rvex_pkg;

  localparam int unsigned RVEX_MEM_BYTES = 65536;

  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0]  F7_ALT   = 7'h20;
  localparam logic [31:0] W_ECALL  = 32'h0000_0073;
  localparam logic [31:0] W_EBREAK = 32'h0010_0073;
  localparam logic [31:0] IMMU_MASK = 32'hFFFF_F000;

  localparam logic [2:0] F3_B  = 3'd0;
  localparam logic [2:0] F3_H  = 3'd1;
  localparam logic [2:0] F3_W  = 3'd2;
  localparam logic [2:0] F3_BU = 3'd4;
  localparam logic [2:0] F3_HU = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ECALL   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef struct packed {
    logic [31:0] instruction_word;
  } instr_t;

  typedef struct packed {
    logic [31:0] start_pc;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        store_valid;
    logic [31:0] store_address;
    logic [31:0] store_data;
    logic [1:0]  store_size;
    logic [31:0] retired_count;
  } result_t;

  // execute stage outcome, handed from the ALU to the write-back stage
  typedef struct packed {
    logic        illegal;
    logic [1:0]  status;
    logic [31:0] npc;
    logic        wr;
    logic [4:0]  rd;
    logic [31:0] val;
    logic        is_load;
    logic [2:0]  ld_f3;
    logic [31:0] mem_addr;
    logic        st;
    logic [31:0] st_addr;
    logic [31:0] st_data;
    logic [1:0]  st_size;
  } ex_res_t;

  function automatic logic [31:0] ld_format(input logic [31:0] w, input logic [2:0] f3);
    logic [31:0] r;
    case (f3)
      F3_B:    r = {{24{w[7]}}, w[7:0]};
      F3_H:    r = {{16{w[15]}}, w[15:0]};
      F3_BU:   r = {24'd0, w[7:0]};
      F3_HU:   r = {16'd0, w[15:0]};
      default: r = w;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/rvex_stream_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance, usually from rvex_pkg.
interface rvex_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/rvex_regfile.sv
// 32 x 32 register file, two registered read ports, one write port.
// Per-entry valid bits give the all-zero reset; the core never writes x0, so it is never marked valid.
module rvex_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        re,
  input  logic [4:0]  ra1,
  input  logic [4:0]  ra2,
  input  logic        we,
  input  logic [4:0]  wa,
  input  logic [31:0] wd,
  output logic [31:0] rd1,
  output logic [31:0] rd2
);
  import rvex_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd1 <= (we && wa == ra1) ? wd : (vld[ra1] ? mem[ra1] : 32'd0);
      rd2 <= (we && wa == ra2) ? wd : (vld[ra2] ? mem[ra2] : 32'd0);
    end
  end
endmodule

// File: hw/rtl/rvex_dmem.sv
// Byte data memory as four byte-lane banks, so any 4-byte window is one read.
// Clears itself after reset, one row per cycle. Uses rvex_pkg.
module rvex_dmem #(
  parameter int unsigned MEM_BYTES = rvex_pkg::RVEX_MEM_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [31:0] rd_addr,
  input  logic        wr_en,
  input  logic [31:0] wr_addr,
  input  logic [31:0] wr_data,
  input  logic [1:0]  wr_size,
  output logic [31:0] rd_data,
  output logic        busy
);
  import rvex_pkg::*;

  // MEM_BYTES is a power of two
  localparam int unsigned AW   = $clog2(MEM_BYTES);
  localparam int unsigned RW   = AW - 2;
  localparam int unsigned ROWS = MEM_BYTES / 4;

  logic [RW-1:0] clr_row;
  logic [7:0]    q [4];
  logic [1:0]    sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == {RW{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      sel <= rd_addr[1:0];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [7:0]    mem [ROWS];
    logic [1:0]    rofs, wofs;
    logic [31:0]   rbyte, wbyte, wsh;
    logic          wen;

    assign rofs  = 2'(k) - rd_addr[1:0];
    assign rbyte = rd_addr + {30'd0, rofs};
    assign wofs  = 2'(k) - wr_addr[1:0];
    assign wbyte = wr_addr + {30'd0, wofs};
    assign wsh   = wr_data >> {wofs, 3'b000};

    always_comb begin
      case (wr_size)
        SZ_BYTE: wen = wr_en && (wofs == 2'd0);
        SZ_HALF: wen = wr_en && (wofs <= 2'd1);
        default: wen = wr_en;
      endcase
    end

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_row] <= 8'd0;
      end else if (wen) begin
        mem[wbyte[AW-1:2]] <= wsh[7:0];
      end
      if (rd_en) begin
        q[k] <= mem[rbyte[AW-1:2]];
      end
    end
  end

  assign rd_data = {q[sel + 2'd3], q[sel + 2'd2], q[sel + 2'd1], q[sel]};
endmodule

// File: hw/rtl/rvex_alu.sv
// Execute-stage decode and compute for one RV32I word.
// Pure combinational; result struct from rvex_pkg.
module rvex_alu (
  input  logic [31:0]       word,
  input  logic [31:0]       pc,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output rvex_pkg::ex_res_t res
);
  import rvex_pkg::*;

  logic [6:0]  opcode, f7;
  logic [4:0]  rd, rs2;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immu, immj;
  logic [31:0] npc, val;
  logic        illegal, wr, taken;
  logic [1:0]  status;
  logic [4:0]  sh;
  logic [31:0] opb;

  assign opcode = word[6:0];
  assign rd     = word[11:7];
  assign f3     = word[14:12];
  assign rs2    = word[24:20];
  assign f7     = word[31:25];
  assign immi   = {{20{word[31]}}, word[31:20]};
  assign imms   = {{20{word[31]}}, word[31:25], word[11:7]};
  assign immb   = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
  assign immu   = word & IMMU_MASK;
  assign immj   = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
  assign opb    = (opcode == OP_REG) ? b : immi;
  assign sh     = (opcode == OP_REG) ? b[4:0] : rs2;

  always_comb begin
    illegal = 1'b0;
    wr      = 1'b0;
    val     = 32'd0;
    status  = ST_OK;
    npc     = pc + 32'd4;
    taken   = 1'b0;
    res     = '0;
    res.mem_addr = a + immi;
    unique case (opcode)
      OP_LOAD: begin
        wr = 1'b1;
        res.is_load = 1'b1;
        res.ld_f3   = f3;
        illegal = !(f3 == F3_B || f3 == F3_H || f3 == F3_W || f3 == F3_BU || f3 == F3_HU);
      end
      OP_IMM, OP_REG: begin
        wr = 1'b1;
        if (opcode == OP_REG && f7 != 7'd0 &&
            !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
          illegal = 1'b1;
        end
        case (f3)
          3'd0: val = (opcode == OP_REG && f7 == F7_ALT) ? a - b : a + opb;
          3'd1: begin
            val = a << sh;
            if (opcode == OP_IMM && f7 != 7'd0) illegal = 1'b1;
          end
          3'd2: val = {31'd0, $signed(a) < $signed(opb)};
          3'd3: val = {31'd0, a < opb};
          3'd4: val = a ^ opb;
          3'd5: begin
            val = (f7 == F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
            if (f7 != F7_ALT && f7 != 7'd0) illegal = 1'b1;
          end
          3'd6: val = a | opb;
          default: val = a & opb;
        endcase
      end
      OP_AUIPC: begin
        wr  = 1'b1;
        val = pc + immu;
      end
      OP_LUI: begin
        wr  = 1'b1;
        val = immu;
      end
      OP_STORE: begin
        illegal = f3[2] || f3 == 3'd3;
        res.st      = 1'b1;
        res.st_addr = a + imms;
        res.st_size = f3[1:0];
        case (f3[1:0])
          SZ_BYTE: res.st_data = {24'd0, b[7:0]};
          SZ_HALF: res.st_data = {16'd0, b[15:0]};
          default: res.st_data = b;
        endcase
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: illegal = 1'b1;
        endcase
        if (taken) npc = pc + immb;
      end
      OP_JALR: begin
        illegal = (f3 != 3'd0);
        wr  = 1'b1;
        val = pc + 32'd4;
        npc = (a + immi) & ~32'd1;
      end
      OP_JAL: begin
        wr  = 1'b1;
        val = pc + 32'd4;
        npc = pc + immj;
      end
      OP_SYSTEM: begin
        if (word == W_ECALL) status = ST_ECALL;
        else if (word != W_EBREAK) illegal = 1'b1;
      end
      default: illegal = 1'b1;
    endcase

    if (illegal) begin
      status = ST_ILLEGAL;
      npc    = pc;
      wr     = 1'b0;
      res.st = 1'b0;
      res.is_load = 1'b0;
    end
    wr = wr && (rd != 5'd0);
    if (!res.st) begin
      res.st_addr = '0;
      res.st_data = '0;
      res.st_size = '0;
    end
    res.illegal = illegal;
    res.status  = status;
    res.npc     = npc;
    res.wr      = wr;
    res.rd      = wr ? rd : 5'd0;
    res.val     = wr ? val : 32'd0;
  end
endmodule

// File: hw/rtl/rv32i_execute_core.sv
// Top level of the RV32I execute core: operand read, execute, write-back.
// Uses rvex_pkg, rvex_stream_if, rvex_regfile, rvex_dmem and rvex_alu.
//
//   channel  dir  payload   beat
//   instr    in   instr_t   one instruction word fetched at the reported pc
//   result   out  result_t  status, next pc, register write, store, count
//   cfg      in   cfg_t     start_pc, also loads the pc
//
// One instruction per cycle while results are taken and the memory is not clearing; a result is offered
// from the write-back register. Stages: register file read, execute plus data memory access, write-back into
// the output register. Results from write-back forward into execute.
// After reset the data memory clears all MEM_BYTES/4 rows with instr.ready low.
// A stalled result freezes the whole pipe.
module rv32i_execute_core #(
  parameter int unsigned MEM_BYTES = rvex_pkg::RVEX_MEM_BYTES
) (
  input logic           clk,
  input logic           rst,
  rvex_stream_if.sink   instr,
  rvex_stream_if.source result,
  rvex_stream_if.sink   cfg
);
  import rvex_pkg::*;

  logic        adv, acc, clr_busy;
  logic        e_valid;
  logic [31:0] e_word;
  logic [31:0] pc, cnt;
  logic [31:0] rf_a, rf_b, op_a, op_b;
  ex_res_t     ex;

  logic        w_valid;
  ex_res_t     w;
  logic [31:0] w_cnt, w_val, ld_word;

  assign adv         = !w_valid || result.ready;
  assign instr.ready = adv && !clr_busy;
  assign acc         = instr.valid && instr.ready;
  assign cfg.ready   = 1'b1;

  rvex_regfile u_rf (
    .clk (clk),
    .rst (rst),
    .re  (adv),
    .ra1 (instr.payload.instruction_word[19:15]),
    .ra2 (instr.payload.instruction_word[24:20]),
    .we  (adv && w_valid && w.wr),
    .wa  (w.rd),
    .wd  (w_val),
    .rd1 (rf_a),
    .rd2 (rf_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_word <= instr.payload.instruction_word;
    end
  end

  assign op_a = (w_valid && w.wr && w.rd == e_word[19:15]) ? w_val : rf_a;
  assign op_b = (w_valid && w.wr && w.rd == e_word[24:20]) ? w_val : rf_b;

  rvex_alu u_alu (
    .word (e_word),
    .pc   (pc),
    .a    (op_a),
    .b    (op_b),
    .res  (ex)
  );

  rvex_dmem #(.MEM_BYTES(MEM_BYTES)) u_dmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .rd_addr (ex.mem_addr),
    .wr_en   (adv && e_valid && ex.st),
    .wr_addr (ex.st_addr),
    .wr_data (ex.st_data),
    .wr_size (ex.st_size),
    .rd_data (ld_word),
    .busy    (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= '0;
      cnt <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        pc <= cfg.payload.start_pc;
      end else if (adv && e_valid && !ex.illegal) begin
        pc <= ex.npc;
      end
      if (adv && e_valid && !ex.illegal) begin
        cnt <= cnt + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (adv) begin
      w_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w     <= ex;
      w_cnt <= ex.illegal ? cnt : cnt + 32'd1;
    end
  end

  assign w_val = w.is_load ? ld_format(ld_word, w.ld_f3) : w.val;

  assign result.valid = w_valid;
  always_comb begin
    result.payload.status        = w.status;
    result.payload.next_pc       = w.npc;
    result.payload.reg_write     = w.wr;
    result.payload.reg_index     = w.rd;
    result.payload.reg_value     = w.wr ? w_val : 32'd0;
    result.payload.store_valid   = w.st;
    result.payload.store_address = w.st_addr;
    result.payload.store_data    = w.st_data;
    result.payload.store_size    = w.st_size;
    result.payload.retired_count = w_cnt;
  end
endmodule

// File: test/tb.sv
// Testbench for rv32i_execute_core: directed and random RV32I words checked
// against an in-bench architectural model. Uses rvex_pkg and rvex_stream_if.
`timescale 1ns / 1ps

module tb;
  import rvex_pkg::*;

  localparam int unsigned MEMB = RVEX_MEM_BYTES;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rvex_stream_if #(.T(instr_t))  instr_if ();
  rvex_stream_if #(.T(result_t)) res_if ();
  rvex_stream_if #(.T(cfg_t))    cfg_if ();

  rv32i_execute_core dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_if),
    .result (res_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  // architectural copy
  logic [31:0] arch_regs [32];
  logic [7:0]  arch_mem [MEMB];
  logic [31:0] arch_pc;
  logic [31:0] arch_retired;

  result_t expected_results [$];
  int      mismatches = 0;
  bit      res_beat;
  result_t res_seen;
  int      res_stall = 0;

  function automatic logic [31:0] mem_load(logic [31:0] addr, int nbytes);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < nbytes; i++) v[8*i +: 8] = arch_mem[(addr + i) % MEMB];
    return v;
  endfunction

  function automatic result_t execute_word(logic [31:0] w);
    result_t     r;
    logic [6:0]  op;
    logic [4:0]  rd, sh;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] pc, a, b, immi, imms, immb, immj, npc, val, addr, lv;
    bit          illegal, wr, taken;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    pc = arch_pc; a = arch_regs[w[19:15]]; b = arch_regs[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    npc = pc + 32'd4;
    r = '0;
    illegal = 0; wr = 0; val = '0; taken = 0;
    case (op)
      OP_LOAD: begin
        addr = a + immi;
        wr = 1;
        case (f3)
          F3_B: begin
            lv  = mem_load(addr, 1);
            val = {{24{lv[7]}}, lv[7:0]};
          end
          F3_H: begin
            lv  = mem_load(addr, 2);
            val = {{16{lv[15]}}, lv[15:0]};
          end
          F3_W:  val = mem_load(addr, 4);
          F3_BU: val = mem_load(addr, 1);
          F3_HU: val = mem_load(addr, 2);
          default: illegal = 1;
        endcase
      end
      OP_IMM: begin
        sh = w[24:20];
        wr = 1;
        case (f3)
          3'd0: val = a + immi;
          3'd1: if (f7 != 7'd0) illegal = 1; else val = a << sh;
          3'd2: val = ($signed(a) < $signed(immi)) ? 32'd1 : 32'd0;
          3'd3: val = (a < immi) ? 32'd1 : 32'd0;
          3'd4: val = a ^ immi;
          3'd5: begin
            if (f7 == F7_ALT) val = $signed(a) >>> sh;
            else if (f7 == 7'd0) val = a >> sh;
            else illegal = 1;
          end
          3'd6: val = a | immi;
          default: val = a & immi;
        endcase
      end
      OP_AUIPC: begin wr = 1; val = pc + (w & IMMU_MASK); end
      OP_LUI: begin wr = 1; val = w & IMMU_MASK; end
      OP_STORE: begin
        if (f3 > 3'd2) illegal = 1;
        else begin
          r.store_valid = 1'b1;
          r.store_address = a + imms;
          r.store_size = f3[1:0];
          r.store_data = (f3 == F3_B) ? (b & 32'hFF) : (f3 == F3_H) ? (b & 32'hFFFF) : b;
          for (int i = 0; i < (1 << f3); i++)
            arch_mem[(r.store_address + i) % MEMB] = r.store_data[8*i +: 8];
        end
      end
      OP_REG: begin
        sh = b[4:0];
        if (f7 != 7'd0 && !(f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) illegal = 1;
        else begin
          wr = 1;
          case (f3)
            3'd0: val = (f7 == F7_ALT) ? a - b : a + b;
            3'd1: val = a << sh;
            3'd2: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: val = (a < b) ? 32'd1 : 32'd0;
            3'd4: val = a ^ b;
            3'd5: if (f7 == F7_ALT) val = $signed(a) >>> sh; else val = a >> sh;
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end
      end
      OP_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = $signed(a) < $signed(b);
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = a < b;
          3'd7: taken = a >= b;
          default: illegal = 1;
        endcase
        if (taken) npc = pc + immb;
      end
      OP_JALR: begin
        if (f3 != 3'd0) illegal = 1;
        else begin
          wr = 1; val = pc + 32'd4; npc = (a + immi) & ~32'd1;
        end
      end
      OP_JAL: begin wr = 1; val = pc + 32'd4; npc = pc + immj; end
      OP_SYSTEM: begin
        if (w == W_ECALL) r.status = ST_ECALL;
        else if (w != W_EBREAK) illegal = 1;
      end
      default: illegal = 1;
    endcase
    if (illegal) begin
      r = '0;
      r.status = ST_ILLEGAL;
      npc = pc;
    end else begin
      if (wr && rd != 5'd0) begin
        arch_regs[rd] = val;
        r.reg_write = 1'b1;
        r.reg_index = rd;
        r.reg_value = val;
      end
      arch_pc = npc;
      arch_retired = arch_retired + 32'd1;
    end
    r.next_pc = npc;
    r.retired_count = arch_retired;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // sends one instruction beat, waiting for the drawn gap first
  task automatic send_word(logic [31:0] w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_if.valid <= 1'b1;
    instr_if.payload <= w;
    do @(negedge clk); while (!instr_if.ready);
    @(posedge clk);
    expected_results.push_back(execute_word(w));
  endtask

  task automatic drain_results();
    instr_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [31:0] v);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= v;
    do @(negedge clk); while (!cfg_if.ready);
    @(posedge clk);
    cfg_if.valid <= 1'b0;
    arch_pc = v;
  endtask

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    int          kind;
    logic [2:0]  pick [6];
    w = $urandom();
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      w[9:7] = w[9:7] & 3'b111; w[11:10] = 2'b00;
      w[19:18] = 2'b00; w[24:23] = 2'b00;
    end
    if (kind < 20) begin
      w[6:0] = OP_REG;
      w[31:25] = ((w[14:12] == 3'd0 || w[14:12] == 3'd5) && w[31]) ? F7_ALT : 7'd0;
    end else if (kind < 35) begin
      w[6:0] = OP_IMM;
      if (w[14:12] == 3'd1) w[31:25] = 7'd0;
      if (w[14:12] == 3'd5) w[31:25] = w[31] ? F7_ALT : 7'd0;
    end else if (kind < 50) begin
      w[6:0] = OP_LOAD;
      pick = '{F3_B, F3_H, F3_W, F3_BU, F3_HU, F3_W};
      w[14:12] = pick[$urandom_range(0, 5)];
    end else if (kind < 62) begin
      w[6:0] = OP_STORE;
      w[14:12] = 3'($urandom_range(0, 2));
    end else if (kind < 72) begin
      w[6:0] = w[0] ? OP_LUI : OP_AUIPC;
    end else if (kind < 82) begin
      w[6:0] = OP_BRANCH;
      pick = '{3'd0, 3'd1, 3'd4, 3'd5, 3'd6, 3'd7};
      w[14:12] = pick[$urandom_range(0, 5)];
    end else if (kind < 88) begin
      w[6:0] = OP_JAL;
    end else if (kind < 92) begin
      w[6:0] = OP_JALR;
      w[14:12] = 3'd0;
    end else if (kind < 95) begin
      w = w[0] ? W_ECALL : W_EBREAK;
    end else begin
      w = $urandom();
    end
    return w;
  endfunction

  task automatic test_directed();
    send_word(32'hFFFFF0B7);                               // lui x1, 0xFFFFF
    send_word(enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OP_IMM));   // addi x2, x0, -1
    send_word(enc_i(12'h7FF, 5'd1, 3'd0, 5'd3, OP_IMM));
    send_word(enc_r(7'd0, 5'd2, 5'd1, 3'd0, 5'd0, OP_REG)); // write to x0
    send_word(enc_r(F7_ALT, 5'd2, 5'd3, 3'd0, 5'd4, OP_REG));
    send_word(enc_r(F7_ALT, 5'd2, 5'd1, 3'd5, 5'd5, OP_REG));
    send_word(enc_i(12'h01F, 5'd2, 3'd1, 5'd6, OP_IMM));
    send_word(enc_i(12'h41F, 5'd6, 3'd5, 5'd7, OP_IMM));
    send_word(enc_i(12'h01F, 5'd6, 3'd5, 5'd8, OP_IMM));
    send_word(enc_r(7'd0, 5'd2, 5'd1, 3'd2, 5'd9, OP_REG));
    send_word(enc_r(7'd0, 5'd2, 5'd1, 3'd3, 5'd10, OP_REG));
    // misaligned word store wrapping past the top of memory
    send_word({7'h7F, 5'd1, 5'd0, F3_W, 5'h1F, OP_STORE});
    send_word({7'h00, 5'd2, 5'd0, F3_H, 5'h03, OP_STORE});
    send_word(enc_i(12'hFFF, 5'd0, F3_W, 5'd11, OP_LOAD));
    send_word(enc_i(12'hFFF, 5'd0, F3_B, 5'd12, OP_LOAD));
    send_word(enc_i(12'hFFF, 5'd0, F3_BU, 5'd13, OP_LOAD));
    send_word(enc_i(12'h002, 5'd0, F3_H, 5'd14, OP_LOAD));
    send_word(enc_i(12'h002, 5'd0, F3_HU, 5'd15, OP_LOAD));
    send_word(enc_i(12'h003, 5'd3, 3'd0, 5'd16, OP_JALR));  // odd base and odd offset
    send_word({1'b1, 10'h3FF, 1'b1, 8'hFF, 5'd17, OP_JAL});
    send_word({7'h7F, 5'd2, 5'd1, 3'd1, 5'h1F, OP_BRANCH});
    send_word(W_ECALL);
    send_word(W_EBREAK);
    send_word(32'h0000000F);                               // fence
    send_word(enc_r(7'h01, 5'd2, 5'd1, 3'd0, 5'd18, OP_REG));
    send_word(enc_i(12'h000, 5'd0, 3'd3, 5'd19, OP_LOAD));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  // result side: sample at the falling edge, act at the rising one
  always @(negedge clk) begin
    res_beat = res_if.valid && res_if.ready;
    res_seen = res_if.payload;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_beat) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result beat with none expected: %p", res_seen);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (res_seen !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p\n          actual   %p", e, res_seen);
          end
        end
        res_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (res_stall > 0) res_stall--;
      res_if.ready <= (res_stall == 0);
    end
  end

  initial begin
    instr_if.valid = 1'b0;
    instr_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEMB; i++) arch_mem[i] = '0;
    arch_pc = '0;
    arch_retired = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_start_pc(32'h0000_0000);
    test_directed();
    test_random(320);
    write_start_pc(32'hFFFF_FFF0);
    test_random(320);
    write_start_pc(32'hFFFF_FFFF);
    test_random(320);
    write_start_pc($urandom());
    test_random(340);
    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: rv32i_execute_core.f
hw/rtl/rvex_pkg.sv
hw/rtl/rvex_stream_if.sv
hw/rtl/rvex_regfile.sv
hw/rtl/rvex_dmem.sv
hw/rtl/rvex_alu.sv
hw/rtl/rv32i_execute_core.sv
test/tb.sv
